// ----- rtl/atc_pkg.sv -----
// Shared types, constants and address helpers for the address translation cache.
package atc_pkg;

    localparam int SETS         = 16;
    localparam int WAYS         = 4;
    localparam int PAYLOAD_BITS = 32;
    localparam int ENTRIES      = SETS * WAYS;
    localparam int SET_BITS     = $clog2(SETS);
    localparam int WAY_BITS     = $clog2(WAYS);
    localparam int IDX_BITS     = SET_BITS + WAY_BITS;
    localparam int TAG_BITS     = 16;
    localparam int ADDR_BITS    = 32;
    localparam int OUT_PAY_BITS = 32;

    // 4K pages: page number starts at bit 12; 8K pages at bit 13
    localparam int PAGE_SHIFT_4K = 12;
    localparam int PAGE_SHIFT_8K = 13;

    typedef enum logic [2:0] {
        FN_LOOKUP     = 3'd0,
        FN_SELECT     = 3'd1,
        FN_TICK       = 3'd2,
        FN_FILL       = 3'd3,
        FN_FLUSH_ALL  = 3'd4,
        FN_FLUSH_NG   = 3'd5,
        FN_FLUSH_PAGE = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } state_t;

    typedef struct packed {
        logic [2:0]              func;
        logic [ADDR_BITS-1:0]    vaddr;
        logic                    sup_mode;
        logic [WAY_BITS-1:0]     fill_way;
        logic                    fill_global;
        logic [OUT_PAY_BITS-1:0] fill_payload;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic [WAY_BITS-1:0]     way;
        logic [OUT_PAY_BITS-1:0] payload;
    } rsp_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]     tag;
        logic                    space;
        logic                    glob;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic match;
        logic drop;
    } cmp_t;

    function automatic logic [SET_BITS-1:0] set_of(input logic [ADDR_BITS-1:0] addr,
                                                   input logic page8k);
        logic [SET_BITS-1:0] s;
        if (page8k)
            s = addr[PAGE_SHIFT_8K +: SET_BITS];
        else
            s = addr[PAGE_SHIFT_4K +: SET_BITS];
        return s;
    endfunction

    function automatic logic [TAG_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] addr,
                                                   input logic page8k);
        logic [TAG_BITS-1:0] t;
        if (page8k)
            t = {1'b0, addr[ADDR_BITS-1:PAGE_SHIFT_8K+SET_BITS]};
        else
            t = addr[ADDR_BITS-1:PAGE_SHIFT_4K+SET_BITS];
        return t;
    endfunction

endpackage

// ----- rtl/address_translation_cache_4way.sv -----
// Top level: 16-set 4-way address translation cache with a way-at-a-time sequencer.
// Select, tick, fill, flush all and unused codes give their result in the cycle after accept.
// Lookup and page flush walk the set one way at a time, each way an entry RAM read (READ) then a
// compare (CMP). Non-global flush walks all 64 entries in the same way.
// One request at a time; the next request is taken only once the result has been taken.
// Reset (async, active low) clears valid bits, replace counter, page size and the sequencer.
module address_translation_cache_4way
    import atc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_data
);

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [WAY_BITS-1:0] ctr_reg, ctr_next;
    logic                page8k_reg;
    rsp_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                in_fire;
    logic [SET_BITS-1:0] in_set;
    logic [TAG_BITS-1:0] in_tag;
    logic [WAY_BITS-1:0] victim;
    logic                scan_last;
    logic                scan_done;
    logic                ram_we;
    logic [IDX_BITS-1:0] ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    entry_t              ram_rdata;
    cmp_t                cmp;

    // Entry store: tag, space, global mark and payload, indexed by {set, way}
    atc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // One compare unit serves every way of every walk
    atc_cmp u_cmp (
        .ent       (ram_rdata),
        .ent_valid (valid_reg[idx_reg]),
        .key_tag   (tag_reg),
        .key_space (req_reg.sup_mode),
        .res       (cmp)
    );

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign in_set    = set_of(in_data.vaddr, page8k_reg);
    assign in_tag    = tag_of(in_data.vaddr, page8k_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Victim: first invalid way of the set, else the replace counter
    always_comb
    begin
        victim = ctr_reg;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!valid_reg[{in_set, WAY_BITS'(w)}])
            begin
                victim = WAY_BITS'(w);
            end
        end
    end

    // A walk ends at the last way of the set, or at the last entry for a non-global flush
    always_comb
    begin
        if (req_reg.func == FN_FLUSH_NG)
        begin
            scan_last = (idx_reg == IDX_BITS'(ENTRIES - 1));
            scan_done = (state_reg == ST_CMP) && scan_last;
        end
        else
        begin
            scan_last = (idx_reg[WAY_BITS-1:0] == WAY_BITS'(WAYS - 1));
            scan_done = (state_reg == ST_CMP) && (cmp.match || scan_last);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_data.func == FN_LOOKUP || in_data.func == FN_FLUSH_PAGE
                                || in_data.func == FN_FLUSH_NG))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = scan_done ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        req_next       = req_reg;
        tag_next       = tag_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        ctr_next       = ctr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = {in_set, in_data.fill_way};
        ram_wdata      = '{tag: in_tag, space: in_data.sup_mode,
                           glob: in_data.fill_global,
                           payload: in_data.fill_payload[PAYLOAD_BITS-1:0]};
        ram_re         = 1'b0;

        // Drop the result once the consumer takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_next = in_data;
                    tag_next = in_tag;
                    out_next = '0;
                    unique case (in_data.func)
                        FN_LOOKUP, FN_FLUSH_PAGE:
                        begin
                            idx_next = {in_set, WAY_BITS'(0)};
                        end
                        FN_FLUSH_NG:
                        begin
                            idx_next = '0;
                        end
                        FN_SELECT:
                        begin
                            out_next.way   = victim;
                            out_valid_next = 1'b1;
                        end
                        FN_TICK:
                        begin
                            ctr_next       = ctr_reg + WAY_BITS'(1);
                            out_valid_next = 1'b1;
                        end
                        FN_FILL:
                        begin
                            ram_we                                = 1'b1;
                            valid_next[{in_set, in_data.fill_way}] = 1'b1;
                            out_valid_next                        = 1'b1;
                        end
                        FN_FLUSH_ALL:
                        begin
                            valid_next     = '0;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_CMP:
            begin
                unique case (req_reg.func)
                    FN_LOOKUP:
                    begin
                        if (cmp.match)
                        begin
                            out_next.hit     = 1'b1;
                            out_next.way     = idx_reg[WAY_BITS-1:0];
                            out_next.payload = ram_rdata.payload;
                        end
                    end
                    FN_FLUSH_PAGE:
                    begin
                        if (cmp.match)
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (cmp.drop)
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                    end
                endcase
                // Advance to the next entry or hand off the result
                if (scan_done)
                begin
                    out_valid_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_BITS'(1);
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            ctr_reg       <= '0;
            page8k_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                page8k_reg <= cfg_data;
            end
        end
    end

    // Hold request fields and result payload; no reset needed
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        tag_reg <= tag_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

endmodule

// ----- rtl/atc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module atc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/atc_cmp.sv -----
// Shared entry compare unit: tag/space match and non-global flush check.
module atc_cmp
    import atc_pkg::*;
(
    input  entry_t              ent,
    input  logic                ent_valid,
    input  logic [TAG_BITS-1:0] key_tag,
    input  logic                key_space,
    output cmp_t                res
);

    logic space_eq;

    assign space_eq  = (ent.space == key_space);
    assign res.match = ent_valid && space_eq && (ent.tag == key_tag);
    assign res.drop  = ent_valid && space_eq && !ent.glob;

endmodule
